@@ rtl/kpd_pkg.sv @@
// Shared types and constants for the Kimura protein distance block.
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

	// Column count limit and count width (holds MAX_COLUMNS itself)
	localparam int MAX_COLUMNS = 65536;
	localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);

	// Field widths
	localparam int RES_W  = 8;
	localparam int DIST_W = 16;

	// Shared multiplier and wide operand widths
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int WIDE_W = 2 * CNT_W + 1;
	localparam int TOP_BIT = WIDE_W - 1;
	localparam int EXP_W  = $clog2(WIDE_W);
	localparam int FRAC_W = 24;
	localparam int LOG_W  = EXP_W + FRAC_W;
	localparam int FCNT_W = $clog2(FRAC_W);

	// ln(2) in Q0.32, rounding position of the final product, saturation value
	localparam logic [MUL_W-1:0]  LN2_Q32      = 32'd2977044472;
	localparam int                RND_SHIFT    = 43;
	localparam logic [PROD_W-1:0] RND_BIAS     = PROD_W'(1) << (RND_SHIFT - 1);
	localparam logic [DIST_W-1:0] CAP_DISTANCE = 16'd42623;

	// Reset value of the gap code register
	localparam logic [RES_W-1:0] GAP_RESET = 8'd45;

	// Register map
	localparam logic REG_GAP_CODE = 1'b0;

	// One input column
	typedef struct packed {
		logic [RES_W-1:0] residue_a;
		logic [RES_W-1:0] residue_b;
		logic             last;
	} kpd_in_t;

	// One result
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              capped;
	} kpd_out_t;

	// Running counts handed from the column counter to the sequencer
	typedef struct packed {
		logic [CNT_W-1:0] identity;
		logic [CNT_W-1:0] nongap;
	} kpd_counts_t;

endpackage

`default_nettype wire

@@ rtl/kpd_mul.sv @@
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module kpd_mul
	import kpd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [MUL_W-1:0]  op_a,
	input  wire logic [MUL_W-1:0]  op_b,
	output logic      [PROD_W-1:0] prod_q
);

	// Register the full product every cycle
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

endmodule

`default_nettype wire

@@ rtl/kpd_counter.sv @@
// Column counter: non-gap and identity counts over one row pair.
`timescale 1ns / 1ps
`default_nettype none

module kpd_counter
	import kpd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire kpd_in_t          column,
	input  wire logic [RES_W-1:0] gap_code,
	output kpd_counts_t           counts_next
);

	kpd_counts_t counts_q;
	logic        count_en;

	// Count a column only if neither side is a gap and the limit is not reached
	always_comb begin
		count_en    = (column.residue_a != gap_code) && (column.residue_b != gap_code) &&
			(counts_q.nongap < CNT_W'(MAX_COLUMNS));
		counts_next = counts_q;
		if (count_en) begin
			counts_next.nongap = counts_q.nongap + CNT_W'(1);
			if (column.residue_a == column.residue_b) begin
				counts_next.identity = counts_q.identity + CNT_W'(1);
			end
		end
	end

	// Advance on each beat, clear after the last column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
		end else if (accept) begin
			if (column.last) begin
				counts_q <= '0;
			end else begin
				counts_q <= counts_next;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/kpd_seq.sv @@
// Sequencer that computes the distance from the counts on the shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module kpd_seq
	import kpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire kpd_counts_t counts,
	input  wire logic        out_free,
	output logic             idle,
	output logic             done,
	output kpd_out_t         result
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_CHECK = 12'b0000_0000_0010,
		S_SQN   = 12'b0000_0000_0100,
		S_IDN   = 12'b0000_0000_1000,
		S_DIF   = 12'b0000_0001_0000,
		S_MSUB  = 12'b0000_0010_0000,
		S_NORM  = 12'b0000_0100_0000,
		S_SQ    = 12'b0000_1000_0000,
		S_SQW   = 12'b0001_0000_0000,
		S_LN    = 12'b0010_0000_0000,
		S_RND   = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} kpd_state_t;

	kpd_state_t        state_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  id_q;
	logic [WIDE_W-1:0] d_q;
	logic [WIDE_W-1:0] t_q;
	logic [WIDE_W-1:0] m_q;
	logic [WIDE_W-1:0] x_q;
	logic [EXP_W-1:0]  e_q;
	logic [MUL_W-1:0]  mant_q;
	logic [FRAC_W-1:0] frac_q;
	logic [FCNT_W-1:0] fcnt_q;
	logic              sel_q;
	logic [LOG_W-1:0]  ld_q;
	logic [LOG_W-1:0]  lm_q;
	kpd_out_t          result_q;

	logic [MUL_W-1:0]  op_a;
	logic [MUL_W-1:0]  op_b;
	logic [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0]  n_diff;
	logic [CNT_W+4:0]  id_x20;
	logic [CNT_W+4:0]  n_x3;
	logic              cap_hit;
	logic [WIDE_W-1:0] prod_x5;
	logic              sq_bit;
	logic [MUL_W-1:0]  sq_mant;
	logic [FRAC_W-1:0] frac_next;
	logic [LOG_W-1:0]  log_diff;
	logic [PROD_W-1:0] rnd_sum;
	logic [PROD_W-RND_SHIFT-1:0] dist_full;

	// Cap test 20*I < 3*N, exact, or N = 0
	assign n_diff  = n_q - id_q;
	assign id_x20  = {1'b0, id_q, 4'b0} + {3'b0, id_q, 2'b0};
	assign n_x3    = {4'b0, n_q, 1'b0} + {5'b0, n_q};
	assign cap_hit = (n_q == '0) || (id_x20 < n_x3);

	// Five times the low product bits (products here stay below 2^33)
	assign prod_x5 = {prod_q[WIDE_W-3:0], 2'b0} + WIDE_W'(prod_q[WIDE_W-3:0]);

	// One squaring step of the mantissa
	assign sq_bit    = prod_q[PROD_W-1];
	assign sq_mant   = sq_bit ? prod_q[PROD_W-1:MUL_W] : prod_q[PROD_W-2:MUL_W-1];
	assign frac_next = {frac_q[FRAC_W-2:0], sq_bit};

	// Log difference, floored at zero
	assign log_diff = (ld_q > lm_q) ? (ld_q - lm_q) : '0;

	// Round half up after the ln(2) scaling
	assign rnd_sum   = prod_q + RND_BIAS;
	assign dist_full = rnd_sum[PROD_W-1:RND_SHIFT];

	// Select multiplier operands per step
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_SQN: begin
				op_a = MUL_W'(n_q);
				op_b = MUL_W'(n_q);
			end
			S_IDN: begin
				op_a = MUL_W'(id_q);
				op_b = MUL_W'(n_q);
			end
			S_DIF: begin
				op_a = MUL_W'(n_diff);
				op_b = MUL_W'(n_diff);
			end
			S_SQ: begin
				op_a = mant_q;
				op_b = mant_q;
			end
			S_LN: begin
				op_a = MUL_W'(log_diff);
				op_b = LN2_Q32;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	kpd_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= 1'b0;
			fcnt_q  <= '0;
			e_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= cap_hit ? S_DONE : S_SQN;
				end
				S_SQN: begin
					state_q <= S_IDN;
				end
				S_IDN: begin
					state_q <= S_DIF;
				end
				S_DIF: begin
					state_q <= S_MSUB;
				end
				S_MSUB: begin
					sel_q   <= 1'b0;
					e_q     <= EXP_W'(TOP_BIT);
					state_q <= S_NORM;
				end
				S_NORM: begin
					fcnt_q <= '0;
					if (x_q[TOP_BIT] || (e_q == '0)) begin
						state_q <= S_SQ;
					end else begin
						e_q <= e_q - EXP_W'(1);
					end
				end
				S_SQ: begin
					state_q <= S_SQW;
				end
				S_SQW: begin
					if (fcnt_q == FCNT_W'(FRAC_W - 1)) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							e_q     <= EXP_W'(TOP_BIT);
							state_q <= S_NORM;
						end else begin
							state_q <= S_LN;
						end
					end else begin
						fcnt_q  <= fcnt_q + FCNT_W'(1);
						state_q <= S_SQ;
					end
				end
				S_LN: begin
					state_q <= S_RND;
				end
				S_RND: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					n_q  <= counts.nongap;
					id_q <= counts.identity;
				end
			end
			S_CHECK: begin
				result_q.distance <= CAP_DISTANCE;
				result_q.capped   <= 1'b1;
			end
			S_IDN: begin
				d_q <= prod_x5;
			end
			S_DIF: begin
				t_q <= prod_x5;
			end
			S_MSUB: begin
				m_q <= t_q - WIDE_W'(prod_q);
				x_q <= d_q;
			end
			S_NORM: begin
				if (x_q[TOP_BIT] || (e_q == '0)) begin
					mant_q <= x_q[TOP_BIT -: MUL_W];
				end else begin
					x_q <= {x_q[TOP_BIT-1:0], 1'b0};
				end
			end
			S_SQW: begin
				mant_q <= sq_mant;
				frac_q <= frac_next;
				if (fcnt_q == FCNT_W'(FRAC_W - 1)) begin
					if (!sel_q) begin
						ld_q <= {e_q, frac_next};
						x_q  <= m_q;
					end else begin
						lm_q <= {e_q, frac_next};
					end
				end
			end
			S_RND: begin
				result_q.capped <= 1'b0;
				if (dist_full > (PROD_W-RND_SHIFT)'(CAP_DISTANCE)) begin
					result_q.distance <= CAP_DISTANCE;
				end else begin
					result_q.distance <= DIST_W'(dist_full);
				end
			end
			default: begin
			end
		endcase
	end

	assign idle   = (state_q == S_IDLE);
	assign done   = (state_q == S_DONE) && out_free;
	assign result = result_q;

endmodule

`default_nettype wire

@@ rtl/kimura_protein_distance.sv @@
// Top level: APB register, column handshake, result register.
`timescale 1ns / 1ps
`default_nettype none

// Kimura protein distance over one aligned row pair, one column per beat.
// A column with last low only advances the counts. The column with last high
// starts the distance computation; in_ready stays low until it is done.
// A capped or empty row pair goes from the check straight to done. Otherwise
// the work runs on one shared 32x32 multiplier: the product terms in S_SQN,
// S_IDN, S_DIF and S_MSUB, then two base-2 logarithms, each by one-bit
// normalization shifts and then squaring for 24 fraction bits (S_SQ and S_SQW
// per bit), then the ln(2) scaling and rounding in S_LN and S_RND. Columns
// are still taken while a finished result waits in the output register.
// Register 0 at byte address 0: gap_code, 8 bits, reset 45.
module kimura_protein_distance
	import kpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire kpd_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output kpd_out_t         out_data
);

	logic [RES_W-1:0] gap_code_q;
	logic             in_accept;
	kpd_counts_t      counts_next;
	logic             out_free;
	logic             seq_done;
	logic             seq_idle;
	kpd_out_t         seq_result;
	logic             out_valid_q;
	kpd_out_t         out_data_q;

	// Configuration register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_code_q <= GAP_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_GAP_CODE)) begin
			gap_code_q <= pwdata[RES_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GAP_CODE) ? 32'(gap_code_q) : '0;

	// Column beat
	assign in_ready  = seq_idle;
	assign in_accept = in_valid && in_ready;

	kpd_counter u_counter (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.column      (in_data),
		.gap_code    (gap_code_q),
		.counts_next (counts_next)
	);

	kpd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept && in_data.last),
		.counts   (counts_next),
		.out_free (out_free),
		.idle     (seq_idle),
		.done     (seq_done),
		.result   (seq_result)
	);

	// Result register: load when empty or being drained
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			out_data_q <= seq_result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
